FILE: rtl/smap_pkg.sv
// shared constants, types and codes for the moving-average light sensor block
package smap_pkg;

  localparam int SAMPLE_W         = 12;
  localparam int PCT_W            = 7;
  localparam int DEF_WINDOW_DEPTH = 16;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [PCT_W-1:0]    PCT_SPAN      = 7'd100;

  // avg*100/3300 equals avg/33; reciprocal of 33 scaled by 2^17, exact for avg below 32768
  localparam int                  RECIP_SHIFT = 17;
  localparam logic [SAMPLE_W-1:0] RECIP_33    = 12'd3972;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } smap_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } smap_div_stat_t;

endpackage

FILE: rtl/sensor_moving_average_percent_unit.sv
// top level: moving average of light-sensor samples with percent scaling
// Each accepted item (a millivolt sample, saturated to 3300) shifts into a chain of
// WINDOW_DEPTH sample cells; the sample leaving the far end is taken off a running sum.
// The average is the sum divided by the number of samples so far (capped at
// WINDOW_DEPTH), truncated, and the percent is avg/33 (upward) or 100 minus that
// (inverted_scale = 1, the reset value). One item is in work at a time: an item goes
// through the load, divide, multiply and output states; the divider yields SUM_W
// quotient bits, SUM_W = clog2(WINDOW_DEPTH*3300+1) being the width of the running sum.
// The next item is accepted while a result waits in the output register.
module sensor_moving_average_percent_unit #(
  parameter int WINDOW_DEPTH = smap_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smap_pkg::SAMPLE_W-1:0] in_sample_mv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smap_pkg::SAMPLE_W-1:0] out_average_mv,
  output logic [smap_pkg::PCT_W-1:0]    out_light_percent
);
  import smap_pkg::*;

  localparam int SUM_MAX = WINDOW_DEPTH * 3300;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int PROD_W  = 2 * SAMPLE_W;

  smap_state_t state_r, state_nxt;

  logic                inverted_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] sample_sat;
  logic [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
  logic                in_accept;

  logic                div_start;
  logic [SUM_W-1:0]    div_quo;
  smap_div_stat_t      div_stat;

  logic [SAMPLE_W-1:0] avg_c;
  logic [SAMPLE_W-1:0] avg_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PCT_W-1:0]    pct_raw;
  logic [PCT_W-1:0]    pct_c;
  logic                out_load;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [PCT_W-1:0]    out_pct_r;

  assign in_accept  = in_valid && in_ready;
  assign sample_sat = (in_sample_mv > FULL_SCALE_MV) ? FULL_SCALE_MV : in_sample_mv;

  // window chain: newest sample enters cell 0, oldest leaves the last cell
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    smap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_accept),
      .d_in     ((i == 0) ? sample_sat : win_q[(i == 0) ? 0 : i-1]),
      .q_out    (win_q[i])
    );
  end

  always_comb begin
    sum_nxt   = sum_r + SUM_W'(sample_sat) - SUM_W'(win_q[WINDOW_DEPTH-1]);
    count_nxt = (count_r == CNT_W'(WINDOW_DEPTH)) ? count_r : count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      count_r    <= '0;
      inverted_r <= 1'b1;
    end else begin
      if (in_accept) begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        inverted_r <= cfg_wr_data;
      end
    end
  end

  smap_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign avg_c = (div_quo > SUM_W'(FULL_SCALE_MV)) ? FULL_SCALE_MV : div_quo[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      avg_r  <= avg_c;
      prod_r <= avg_c * RECIP_33;
    end
  end

  assign pct_raw = prod_r[RECIP_SHIFT +: PCT_W];
  assign pct_c   = inverted_r ? (PCT_SPAN - pct_raw) : pct_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_LOAD);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  // output register holds a result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r <= avg_r;
      out_pct_r <= pct_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_mv    = out_avg_r;
  assign out_light_percent = out_pct_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(SUM_MAX))
    else $error("running sum beyond full window");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= PCT_SPAN) && (out_avg_r <= FULL_SCALE_MV))
    else $error("result out of range");

endmodule

FILE: rtl/smap_cell.sv
// one window cell: holds a sample and passes it to the next cell on each item
module smap_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [smap_pkg::SAMPLE_W-1:0] d_in,
  output logic [smap_pkg::SAMPLE_W-1:0] q_out
);
  import smap_pkg::*;

  logic [SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= d_in;
    end
  end

  assign q_out = sample_r;

endmodule

FILE: rtl/smap_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module smap_divider #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [DVS_W-1:0]             divisor,
  output logic [DVD_W-1:0]             quotient,
  output smap_pkg::smap_div_stat_t     stat
);
  import smap_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_sh;
  logic             qbit;
  logic [DVS_W:0]   rem_sub;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_nxt = qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: verif/tb_sensor_moving_average_percent_unit.sv
// testbench for the moving-average light sensor block with percent scaling
`timescale 1ns / 1ps

module tb_sensor_moving_average_percent_unit;
  import smap_pkg::*;

  localparam int WINDOW_DEPTH = DEF_WINDOW_DEPTH;
  localparam logic SCALE_UPWARD = 1'b0;
  localparam logic SCALE_INVERTED = 1'b1;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_mv;
    logic [PCT_W-1:0]    light_percent;
  } reading_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample_mv = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_average_mv;
  logic [PCT_W-1:0]    out_light_percent;

  // predictor state
  logic [SAMPLE_W-1:0] ring_samples [WINDOW_DEPTH];
  int unsigned         ring_sum;
  int unsigned         ring_pos;
  int unsigned         ring_fill;
  logic                invert_percent;

  reading_t pending_readings [$];
  int       mismatch_count = 0;
  bit       idle_on = 1'b1;
  int       hold_off_len = 0;

  sensor_moving_average_percent_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_mv     (in_sample_mv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average_mv   (out_average_mv),
    .out_light_percent(out_light_percent)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("sensor_moving_average_percent_unit verification failed");
    $finish;
  end

  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] raw);
    int unsigned clipped;
    int unsigned avg;
    int unsigned pct;
    reading_t    r;
    clipped = (raw > FULL_SCALE_MV) ? int'(FULL_SCALE_MV) : int'(raw);
    ring_sum = ring_sum - ring_samples[ring_pos] + clipped;
    ring_samples[ring_pos] = clipped[SAMPLE_W-1:0];
    ring_pos = (ring_pos + 1 == WINDOW_DEPTH) ? 0 : ring_pos + 1;
    if (ring_fill < WINDOW_DEPTH) ring_fill++;
    avg = ring_sum / ring_fill;
    if (avg > FULL_SCALE_MV) avg = FULL_SCALE_MV;
    pct = (avg * PCT_SPAN) / FULL_SCALE_MV;
    if (invert_percent) pct = PCT_SPAN - pct;
    r.average_mv = avg[SAMPLE_W-1:0];
    r.light_percent = pct[PCT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    reading_t exp_r;
    if (!rst_n) begin
      foreach (ring_samples[i]) ring_samples[i] = '0;
      ring_sum = 0;
      ring_pos = 0;
      ring_fill = 0;
      invert_percent = SCALE_INVERTED;
    end else begin
      if (cfg_wr_en) invert_percent = cfg_wr_data;
      if (in_valid && in_ready) pending_readings.push_back(predict_reading(in_sample_mv));
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result with no item outstanding: average_mv %0d light_percent %0d",
                 out_average_mv, out_light_percent);
          mismatch_count++;
        end else begin
          exp_r = pending_readings.pop_front();
          if (out_average_mv !== exp_r.average_mv) begin
            $error("average_mv expected %0d actual %0d", exp_r.average_mv, out_average_mv);
            mismatch_count++;
          end
          if (out_light_percent !== exp_r.light_percent) begin
            $error("light_percent expected %0d actual %0d",
                   exp_r.light_percent, out_light_percent);
            mismatch_count++;
          end
        end
      end
    end
  end

  // result side: random stalls, or a long hold when a test asks for one
  initial begin : receiver
    int n;
    forever begin
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && rst_n && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // returns just after the edge that took the item
  task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_mv <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_scale(input logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return SAMPLE_W'($urandom_range(0, 3300));
    else if (pick < 17) return SAMPLE_W'($urandom_range(3301, 4095));
    else if (pick == 17) return '0;
    else if (pick == 18) return FULL_SCALE_MV;
    else return '1;
  endfunction

  // window fills from empty, then wraps; extremes and saturation on the inverted scale
  task automatic test_fill_inverted();
    logic [SAMPLE_W-1:0] seq [] = '{12'd0, 12'd4095, 12'd3301, 12'd3300, 12'd3299, 12'd1,
                                    12'd33, 12'd32, 12'd2048, 12'd2047, 12'd1650, 12'd100,
                                    12'd3300, 12'd4095, 12'd4095, 12'd4000, 12'd3300,
                                    12'd0, 12'd0, 12'd0};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_upward_scale();
    logic [SAMPLE_W-1:0] seq [] = '{12'd0, 12'd4095, 12'd33, 12'd32, 12'd3300};
    write_scale(SCALE_UPWARD);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // random samples with runs at one level so the average reaches the scale ends
  task automatic test_random_phase(input logic mode, input int count);
    int                  sent;
    int                  run_len;
    logic [SAMPLE_W-1:0] level;
    write_scale(mode);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        level = random_sample();
        run_len = $urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 4);
        repeat (run_len) send_sample(level);
        sent += run_len;
      end else begin
        send_sample(random_sample());
        sent++;
      end
    end
  endtask

  task automatic test_long_hold();
    hold_off_len = LONG_HOLD_CYCLES;
    repeat (12) send_sample(random_sample());
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_scale(SCALE_INVERTED);
    repeat (120) send_sample(random_sample());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_inverted();
    test_upward_scale();
    test_random_phase(SCALE_INVERTED, 120);
    test_random_phase(SCALE_UPWARD, 120);
    test_long_hold();
    test_random_phase(SCALE_INVERTED, 120);
    test_random_phase(SCALE_UPWARD, 120);
    test_steady_stream();

    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending_readings.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d results never arrived", pending_readings.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("sensor_moving_average_percent_unit verification clean");
    end else begin
      $display("sensor_moving_average_percent_unit verification failed");
    end
    $finish;
  end

endmodule
